// ----- hw/rtl/smx_pkg.sv -----
// ============================================================================
// smx_pkg
// Shared constants and types for the splitmix64 stream bank: field widths,
// the golden step, the finalizer multipliers and shifts, and the bank entry.
// ============================================================================
`default_nettype none

package smx_pkg;

    // Default number of streams in the bank.
    localparam int NUM_STREAMS_DEF = 1024;

    // Field widths.
    localparam int INDEX_W = 10;
    localparam int SEED_W  = 32;
    localparam int VALUE_W = 64;
    localparam int DRAW_W  = 53;

    // Stream step and finalizer constants.
    localparam logic [VALUE_W-1:0] GOLDEN    = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [VALUE_W-1:0] MIX_MUL_A = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [VALUE_W-1:0] MIX_MUL_B = 64'h94d0_49bb_1331_11eb;
    localparam int MIX_SHIFT_A   = 30;
    localparam int MIX_SHIFT_B   = 27;
    localparam int MIX_SHIFT_OUT = 31;

    // One bank entry as read back from the stream store.
    typedef struct packed {
        logic               seeded;
        logic [VALUE_W-1:0] value;
    } t_entry;

endpackage

`default_nettype wire

// ----- hw/rtl/smx_mix.sv -----
// ============================================================================
// smx_mix
// Multi-cycle splitmix64 finalizer. Each 64-bit modular multiply is built
// from three 32x32 partial products that are registered before they are summed.
// ============================================================================
`default_nettype none

module smx_mix (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [smx_pkg::VALUE_W-1:0] i_value,
    output logic                        o_done,
    output logic [smx_pkg::VALUE_W-1:0] o_result
);

    typedef enum logic [5:0] {
        M_IDLE = 6'b000001,
        M_MUL1 = 6'b000010,
        M_SUM1 = 6'b000100,
        M_MUL2 = 6'b001000,
        M_SUM2 = 6'b010000,
        M_DONE = 6'b100000
    } t_mix_state;

    t_mix_state                  r_state, n_state;
    logic [smx_pkg::VALUE_W-1:0] r_x, n_x;
    logic [smx_pkg::VALUE_W-1:0] r_p0;
    logic [31:0]                 r_p1, r_p2;
    logic [smx_pkg::VALUE_W-1:0] w_t, w_k, w_sum;

    // The xor-shift and multiplier constant of the current round.
    always_comb begin
        if (r_state == M_MUL1) begin
            w_t = r_x ^ (r_x >> smx_pkg::MIX_SHIFT_A);
            w_k = smx_pkg::MIX_MUL_A;
        end else begin
            w_t = r_x ^ (r_x >> smx_pkg::MIX_SHIFT_B);
            w_k = smx_pkg::MIX_MUL_B;
        end
    end

    // Low 64 bits of the product, from the registered partial products.
    assign w_sum = r_p0 + {32'(r_p1 + r_p2), 32'd0};

    // Partial products of the shared multiplier.
    always_ff @(posedge i_clk) begin
        r_p0 <= 64'(w_t[31:0]) * 64'(w_k[31:0]);
        r_p1 <= 32'(w_t[31:0] * w_k[63:32]);
        r_p2 <= 32'(w_t[63:32] * w_k[31:0]);
    end

    // Round sequencer.
    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        unique case (r_state) inside
            M_IDLE, M_DONE: begin
                if (i_start) begin
                    n_x     = i_value;
                    n_state = M_MUL1;
                end else begin
                    n_state = M_IDLE;
                end
            end
            M_MUL1: n_state = M_SUM1;
            M_SUM1: begin
                n_x     = w_sum;
                n_state = M_MUL2;
            end
            M_MUL2: n_state = M_SUM2;
            M_SUM2: begin
                n_x     = w_sum ^ (w_sum >> smx_pkg::MIX_SHIFT_OUT);
                n_state = M_DONE;
            end
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
    end

    assign o_done   = (r_state == M_DONE);
    assign o_result = r_x;

`ifndef NO_ASSERTIONS
    // A new value is only handed over when the unit is free.
    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == M_IDLE || r_state == M_DONE))
        else $error("finalizer started while busy");

    // Every start produces a result after the MUL1, SUM1, MUL2 and SUM2 rounds.
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##5 o_done)
        else $error("finalizer latency broken");

    // The result comes only out of the second summing round.
    a_done_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == M_SUM2))
        else $error("finalizer done without second round");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/smx_store.sv -----
// ============================================================================
// smx_store
// Stream store: a value memory and a seeded-flag memory sharing one write and
// one read address. The flag memory is swept to zero after reset.
// ============================================================================
`default_nettype none

module smx_store #(
    parameter int DEPTH  = smx_pkg::NUM_STREAMS_DEF,
    parameter int ADDR_W = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output smx_pkg::t_entry             o_rdata,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [smx_pkg::VALUE_W-1:0] i_wdata,
    output logic                        o_busy
);

    logic [smx_pkg::VALUE_W-1:0] r_value_mem  [DEPTH];
    logic                        r_seeded_mem [DEPTH];
    logic                        r_clearing;
    logic [ADDR_W-1:0]           r_clr_addr;
    smx_pkg::t_entry             r_rdata;

    // Clearing sweep over the seeded flags after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Seeded-flag memory: cleared by the sweep, set by every write outside the sweep.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_seeded_mem[r_clr_addr] <= 1'b0;
        end else if (i_we) begin
            r_seeded_mem[i_waddr] <= 1'b1;
        end
    end

    // Value memory, and the registered read of both memories.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_value_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata.seeded <= r_seeded_mem[i_raddr];
            r_rdata.value  <= r_value_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clearing;

endmodule

`default_nettype wire

// ----- hw/rtl/splitmix64_stream_bank_core.sv -----
// ============================================================================
// splitmix64_stream_bank_core
// Bank of independent splitmix64 streams with lazy seeding; each input word
// names a stream and returns one 53-bit uniform draw.
// ============================================================================
// Usage:
// The input channel (i_in_valid / o_in_ready) carries a stream index; the
// output channel (o_out_valid / i_out_ready) returns one 0.53 fraction per
// input word, in order. i_base_seed is written with i_base_seed_we; the user
// is to write it while the block is idle, which the block does not enforce,
// and it affects only streams seeded after the write. One word is worked on
// at a time; the run time is set by the shared finalizer. A seeded stream
// is read, run through the finalizer once and put in the output register;
// the first use of a stream runs the finalizer twice, for the seed and the
// draw. An index beyond the bank skips store and finalizer and returns zero.
// After reset the seeded flags are swept, one entry a cycle, which holds
// o_in_ready low until all DEPTH entries (at most 1024) are cleared.
// The output register decouples the sides: a new word is accepted while a
// draw waits; if the receiver still stalls when the next draw is done, the
// block holds it and accepts nothing more until the output register frees.
// ============================================================================
`default_nettype none

module splitmix64_stream_bank_core #(
    parameter int NUM_STREAMS = smx_pkg::NUM_STREAMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [smx_pkg::INDEX_W-1:0]        i_stream_index,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [smx_pkg::DRAW_W-1:0]         o_uniform_draw,
    input  logic                               i_base_seed_we,
    input  logic signed [smx_pkg::SEED_W-1:0]  i_base_seed
);

    localparam int INDEX_SPAN = 1 << smx_pkg::INDEX_W;
    localparam int DEPTH      = (NUM_STREAMS < INDEX_SPAN) ? NUM_STREAMS : INDEX_SPAN;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_SEED = 5'b00100,
        S_DRAW = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                             r_state, n_state;
    logic signed [smx_pkg::SEED_W-1:0]  r_base_seed;
    logic [ADDR_W-1:0]                  r_addr;
    logic                               r_in_range;
    logic [smx_pkg::VALUE_W-1:0]        r_seed_sum;
    logic [smx_pkg::DRAW_W-1:0]         r_draw;
    logic                               r_out_valid;
    logic [smx_pkg::DRAW_W-1:0]         r_out_draw;

    logic                               w_accept;
    logic                               w_in_range;
    logic                               w_busy;
    smx_pkg::t_entry                    w_rdata;
    logic                               w_store_we;
    logic [smx_pkg::VALUE_W-1:0]        w_adv;
    logic                               w_mix_start;
    logic [smx_pkg::VALUE_W-1:0]        w_mix_in;
    logic                               w_mix_done;
    logic [smx_pkg::VALUE_W-1:0]        w_mix_result;
    logic                               w_out_load;

    assign o_in_ready = (r_state == S_IDLE) && !w_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = (32'(i_stream_index) < 32'(DEPTH));
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_seed <= '0;
        end else if (i_base_seed_we) begin
            r_base_seed <= i_base_seed;
        end
    end

    // Stream value advanced by one golden step, from memory or a fresh seed.
    assign w_adv = ((r_state == S_SEED) ? w_mix_result : w_rdata.value) + smx_pkg::GOLDEN;

    // Sequencer control.
    always_comb begin
        n_state     = r_state;
        w_store_we  = 1'b0;
        w_mix_start = 1'b0;
        w_mix_in    = w_adv;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_range ? S_READ : S_OUT;
                end
            end
            S_READ: begin
                w_mix_start = 1'b1;
                if (w_rdata.seeded) begin
                    w_store_we = 1'b1;
                    n_state    = S_DRAW;
                end else begin
                    w_mix_in = r_seed_sum;
                    n_state  = S_SEED;
                end
            end
            S_SEED: begin
                if (w_mix_done) begin
                    w_store_we  = 1'b1;
                    w_mix_start = 1'b1;
                    n_state     = S_DRAW;
                end
            end
            S_DRAW: begin
                if (w_mix_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Word registers: address, range flag, seed start value and draw.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr     <= i_stream_index[ADDR_W-1:0];
            r_in_range <= w_in_range;
            r_seed_sum <= {{(smx_pkg::VALUE_W - smx_pkg::SEED_W){r_base_seed[smx_pkg::SEED_W-1]}},
                           r_base_seed}
                        + 64'(smx_pkg::GOLDEN * 64'(i_stream_index))
                        + smx_pkg::GOLDEN;
            r_draw     <= '0;
        end else if (r_state == S_DRAW && w_mix_done) begin
            r_draw <= w_mix_result[smx_pkg::VALUE_W-1 -: smx_pkg::DRAW_W];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_draw <= r_draw;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_uniform_draw = r_out_draw;

    smx_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (w_accept),
        .i_raddr (i_stream_index[ADDR_W-1:0]),
        .o_rdata (w_rdata),
        .i_we    (w_store_we),
        .i_waddr (r_addr),
        .i_wdata (w_adv),
        .o_busy  (w_busy)
    );

    smx_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mix_start),
        .i_value  (w_mix_in),
        .o_done   (w_mix_done),
        .o_result (w_mix_result)
    );

`ifndef NO_ASSERTIONS
    // An index beyond the bank always yields a zero draw.
    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_in_range) |-> (r_draw == '0))
        else $error("out-of-range index gave a nonzero draw");

    // Finalizer results arrive only while a word is being worked on.
    a_mix_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mix_done |-> (r_state == S_SEED || r_state == S_DRAW))
        else $error("finalizer result with no word in flight");

    // The datapath never writes the store during the clearing sweep.
    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_store_we |-> !w_busy)
        else $error("store written during clearing sweep");
`endif

endmodule

`default_nettype wire
